// File: rtl/cct_pkg.sv
package cct_pkg;

    localparam int MAX_ROWS_DEF   = 256;
    localparam int MAX_COLS_DEF   = 256;
    localparam int LABEL_BITS_DEF = 8;

    localparam int DIM_W   = 9;
    localparam int LABEL_W = 8;
    localparam int KIND_W  = 3;
    localparam int DIR_W   = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_START    = 3'd0,
        KIND_STEP     = 3'd1,
        KIND_ISOLATED = 3'd2,
        KIND_ABSENT   = 3'd3,
        KIND_DONE     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_NUM_ROWS  = 2'd0,
        REG_NUM_COLS  = 2'd1,
        REG_MAX_LABEL = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_SEEK  = 2'd0,
        PH_TRACE = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    // last zero direction after a move in direction d
    function automatic logic [DIR_W-1:0] zero_dir(input logic [DIR_W-1:0] d);
        logic [DIR_W-1:0] z;
        begin
            case (d)
                3'd0, 3'd1: z = 3'd6;
                3'd2, 3'd3: z = 3'd0;
                3'd4, 3'd5: z = 3'd2;
                default:    z = 3'd4;
            endcase
            return z;
        end
    endfunction

    // row offset: 0 none, 1 minus one, 2 plus one
    function automatic logic [1:0] step_dr(input logic [DIR_W-1:0] d);
        logic [1:0] s;
        begin
            case (d)
                3'd1, 3'd2, 3'd3: s = 2'd1;
                3'd5, 3'd6, 3'd7: s = 2'd2;
                default:          s = 2'd0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [1:0] step_dc(input logic [DIR_W-1:0] d);
        logic [1:0] s;
        begin
            case (d)
                3'd0, 3'd1, 3'd7: s = 2'd2;
                3'd3, 3'd4, 3'd5: s = 2'd1;
                default:          s = 2'd0;
            endcase
            return s;
        end
    endfunction

endpackage

// File: rtl/cct_ram.sv
module cct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/chain_code_contour_tracer_top.sv
// chain code contour tracer
// channels: in (op, pixel_value) and out (kind, row, col, label, direction,
// component_end), each with valid/ready; cfg_valid/cfg_ready with cfg_index
// and cfg_data writes num_rows (0), num_cols (1), max_label (2).
// op 0 loads the next pixel in raster order into the image ram and gives no
// result; when num_cols was written since the last load, the load first
// rebuilds row and column from the position.
// op 1 yields exactly one trace record. a chain step reads one neighbor a
// cycle; a component start scans the image in raster order; all-done gives
// a KIND_DONE record.
// one item is worked on at a time; the result sits in an output register and
// the next item is accepted while it waits, but work on that item stalls
// until the earlier transfer completes.
// reset: area 256 x 256, max_label 1, trace starts at label 1, load position
// 0. the image ram is not cleared: every pixel in the area must be loaded
// before it is traced.
module chain_code_contour_tracer_top
    import cct_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int LABEL_BITS = LABEL_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [LABEL_W-1:0]   pixel_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    kind,
    output logic [DIM_W-1:0]     row,
    output logic [DIM_W-1:0]     col,
    output logic [LABEL_W-1:0]   label,
    output logic [DIR_W-1:0]     direction,
    output logic                 component_end
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam int PW = (RW + 1 > CW + 1) ? RW + 2 : CW + 2; // framed coord width
    localparam int DCW = $clog2(AW + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SEEK  = 6'b000010,
        S_SEEKW = 6'b000100,
        S_NB    = 6'b001000,
        S_OUT   = 6'b010000,
        S_DIV   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]      rows_reg, cols_reg;
    logic [LABEL_W-1:0]    maxl_reg;
    logic [LABEL_BITS-1:0] lab_reg;
    phase_t                phase_reg;
    logic [PW-1:0]         cr_reg, cc_reg, sr_reg, sc_reg;
    logic [DIR_W-1:0]      lzd_reg;
    logic [RW-1:0]         ldr_reg;
    logic [CW-1:0]         ldc_reg;
    logic [AW-1:0]         lpos_reg;
    logic                  cols_dirty_reg;

    // position rebuild after a column count change
    logic [AW-1:0]         div_q_reg;
    logic [CW:0]           div_rem_reg;
    logic [DCW-1:0]        div_cnt_reg;

    logic                  hold_reg;
    logic                  hold_op_reg;
    logic [LABEL_BITS-1:0] hold_px_reg;

    // scan position (loaded coords, zero based)
    logic [RW-1:0]         sr_scan_reg;
    logic [CW-1:0]         sc_scan_reg;
    logic                  scan_last_reg;
    // neighbor search
    logic [DIR_W-1:0]      dir_reg;
    logic [3:0]            cnt_reg;
    logic                  nb_pend_reg;
    logic                  nb_out_reg;
    logic [PW-1:0]         nr_reg, nc_reg;

    logic                  ovalid_reg;
    logic [KIND_W-1:0]     okind_reg;
    logic [DIM_W-1:0]      orow_reg, ocol_reg;
    logic [LABEL_W-1:0]    olab_reg;
    logic [DIR_W-1:0]      odir_reg;
    logic                  oend_reg;

    // clamped dimensions
    logic [RW:0] nrows;
    logic [CW:0] ncols;
    always_comb
    begin
        if (rows_reg == '0)
            nrows = (RW+1)'(1);
        else if ({{(PW){1'b0}}, rows_reg} > (PW+DIM_W)'(MAX_ROWS))
            nrows = (RW+1)'(MAX_ROWS);
        else
            nrows = (RW+1)'(rows_reg);
        if (cols_reg == '0)
            ncols = (CW+1)'(1);
        else if ({{(PW){1'b0}}, cols_reg} > (PW+DIM_W)'(MAX_COLS))
            ncols = (CW+1)'(MAX_COLS);
        else
            ncols = (CW+1)'(cols_reg);
    end

    // load position, wrapped to the origin when it lies beyond the area
    logic          ld_stale;
    logic [RW-1:0] ld_r;
    logic [CW-1:0] ld_c;
    logic [AW-1:0] ld_pos;
    logic          ld_col_last, ld_row_last;
    always_comb
    begin
        ld_stale    = ((RW+1)'(ldr_reg) >= nrows) || ((CW+1)'(ldc_reg) >= ncols);
        ld_r        = ld_stale ? '0 : ldr_reg;
        ld_c        = ld_stale ? '0 : ldc_reg;
        ld_pos      = ld_stale ? '0 : lpos_reg;
        ld_col_last = (CW+1)'(ld_c) + (CW+1)'(1) >= ncols;
        ld_row_last = (RW+1)'(ld_r) + (RW+1)'(1) >= nrows;
    end

    // one restoring division step: position / ncols
    logic [CW+1:0] div_sh, div_sub;
    logic          div_ge;
    always_comb
    begin
        div_sh  = {div_rem_reg, div_q_reg[AW-1]};
        div_ge  = div_sh >= (CW+2)'(ncols);
        div_sub = div_sh - (CW+2)'(ncols);
    end

    // ram
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [LABEL_BITS-1:0] ram_rdata;

    cct_ram #(.WIDTH(LABEL_BITS), .DEPTH(1 << AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (hold_px_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // neighbor coordinate for current dir
    logic [PW-1:0] ncr, ncc;
    logic          nb_in;
    always_comb
    begin
        case (step_dr(dir_reg))
            2'd1:    ncr = cr_reg - PW'(1);
            2'd2:    ncr = cr_reg + PW'(1);
            default: ncr = cr_reg;
        endcase
        case (step_dc(dir_reg))
            2'd1:    ncc = cc_reg - PW'(1);
            2'd2:    ncc = cc_reg + PW'(1);
            default: ncc = cc_reg;
        endcase
        nb_in = (ncr != '0) && (ncr <= PW'(nrows)) && (ncc != '0) && (ncc <= PW'(ncols));
    end

    logic work_go;
    assign work_go   = hold_reg && (state_reg == S_IDLE) && !ovalid_reg;
    assign in_ready  = !hold_reg;
    assign cfg_ready = 1'b1;

    logic lab_over;
    assign lab_over = (lab_reg == '0) || ({{(LABEL_W){1'b0}}, lab_reg} > (LABEL_W+LABEL_BITS)'(maxl_reg));

    logic nb_hit;
    assign nb_hit = nb_pend_reg && nb_out_reg == 1'b0 && (ram_rdata == lab_reg);

    always_comb
    begin
        ram_we    = work_go && !hold_op_reg && !cols_dirty_reg;
        ram_waddr = {ld_r, ld_c};
        ram_re    = 1'b0;
        ram_raddr = {sr_scan_reg, sc_scan_reg};
        if (state_reg == S_SEEK)
            ram_re = 1'b1;
        else if (state_reg == S_NB)
        begin
            ram_re    = 1'b1;
            ram_raddr = {RW'(ncr - PW'(1)), CW'(ncc - PW'(1))};
        end
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (work_go && !hold_op_reg && cols_dirty_reg)
                    state_next = S_DIV;
                else if (work_go && hold_op_reg && phase_reg == PH_SEEK && !lab_over)
                    state_next = S_SEEK;
                else if (work_go && hold_op_reg && phase_reg == PH_TRACE)
                    state_next = S_NB;
            end
            S_SEEK:  state_next = S_SEEKW;
            S_SEEKW:
            begin
                if (ram_rdata == lab_reg || scan_last_reg)
                    state_next = S_OUT;
                else
                    state_next = S_SEEK;
            end
            S_NB:
            begin
                if (nb_hit || cnt_reg == 4'd8)
                    state_next = S_OUT;
            end
            S_OUT:   state_next = S_IDLE;
            S_DIV:
            begin
                if (div_cnt_reg == DCW'(AW))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic [PW-1:0] pr_full, pc_full;
    assign pr_full = PW'(sr_scan_reg) + PW'(1);
    assign pc_full = PW'(sc_scan_reg) + PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rows_reg    <= DIM_W'(256);
            cols_reg    <= DIM_W'(256);
            maxl_reg    <= LABEL_W'(1);
            lab_reg     <= LABEL_BITS'(1);
            phase_reg   <= PH_SEEK;
            cr_reg      <= '0;
            cc_reg      <= '0;
            sr_reg      <= '0;
            sc_reg      <= '0;
            lzd_reg     <= 3'd4;
            ldr_reg     <= '0;
            ldc_reg     <= '0;
            lpos_reg    <= '0;
            cols_dirty_reg <= 1'b0;
            div_q_reg   <= '0;
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
            hold_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
            nb_pend_reg <= 1'b0;
            sr_scan_reg <= '0;
            sc_scan_reg <= '0;
            scan_last_reg <= 1'b0;
            dir_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_NUM_ROWS:  rows_reg <= cfg_data;
                    REG_NUM_COLS:
                    begin
                        cols_reg       <= cfg_data;
                        cols_dirty_reg <= 1'b1;
                    end
                    REG_MAX_LABEL: maxl_reg <= cfg_data[LABEL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                hold_reg <= 1'b1;
            if (out_valid && out_ready)
                ovalid_reg <= 1'b0;

            if (work_go)
            begin
                if (!hold_op_reg)
                begin
                    if (cols_dirty_reg)
                    begin
                        // row and column depend on the column count
                        div_q_reg   <= lpos_reg;
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                    end
                    else
                    begin
                        hold_reg <= 1'b0;
                        if (ld_col_last)
                        begin
                            ldc_reg <= '0;
                            if (ld_row_last)
                            begin
                                ldr_reg  <= '0;
                                lpos_reg <= '0;
                            end
                            else
                            begin
                                ldr_reg  <= ld_r + RW'(1);
                                lpos_reg <= ld_pos + AW'(1);
                            end
                        end
                        else
                        begin
                            ldr_reg  <= ld_r;
                            ldc_reg  <= ld_c + CW'(1);
                            lpos_reg <= ld_pos + AW'(1);
                        end
                    end
                end
                else if (phase_reg == PH_DONE || (phase_reg == PH_SEEK && lab_over))
                begin
                    hold_reg   <= 1'b0;
                    phase_reg  <= PH_DONE;
                    ovalid_reg <= 1'b1;
                    okind_reg  <= KIND_DONE;
                    orow_reg   <= '0;
                    ocol_reg   <= '0;
                    olab_reg   <= '0;
                    odir_reg   <= '0;
                    oend_reg   <= 1'b0;
                end
                else if (phase_reg == PH_SEEK)
                begin
                    sr_scan_reg   <= '0;
                    sc_scan_reg   <= '0;
                    scan_last_reg <= (nrows == (RW+1)'(1)) && (ncols == (CW+1)'(1));
                end
                else
                begin
                    dir_reg     <= lzd_reg + 3'd1;
                    cnt_reg     <= '0;
                    nb_pend_reg <= 1'b0;
                end
            end

            if (state_reg == S_DIV)
            begin
                if (div_cnt_reg == DCW'(AW))
                begin
                    cols_dirty_reg <= 1'b0;
                    if ((AW+1)'(div_q_reg) >= (AW+1)'(nrows))
                    begin
                        ldr_reg  <= '0;
                        ldc_reg  <= '0;
                        lpos_reg <= '0;
                    end
                    else
                    begin
                        ldr_reg <= RW'(div_q_reg);
                        ldc_reg <= CW'(div_rem_reg);
                    end
                end
                else
                begin
                    div_q_reg   <= {div_q_reg[AW-2:0], div_ge};
                    div_rem_reg <= div_ge ? div_sub[CW:0] : div_sh[CW:0];
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                end
            end

            if (state_reg == S_SEEKW)
            begin
                if (ram_rdata == lab_reg)
                begin
                    sr_reg    <= pr_full;
                    sc_reg    <= pc_full;
                    cr_reg    <= pr_full;
                    cc_reg    <= pc_full;
                    lzd_reg   <= 3'd4;
                    phase_reg <= PH_TRACE;
                    okind_reg <= KIND_START;
                    orow_reg  <= DIM_W'(pr_full);
                    ocol_reg  <= DIM_W'(pc_full);
                    oend_reg  <= 1'b0;
                end
                else if (scan_last_reg)
                begin
                    okind_reg <= KIND_ABSENT;
                    orow_reg  <= '0;
                    ocol_reg  <= '0;
                    oend_reg  <= 1'b1;
                    lab_reg   <= lab_reg + LABEL_BITS'(1);
                end
                else
                begin
                    if ((CW+1)'(sc_scan_reg) + (CW+1)'(1) >= ncols)
                    begin
                        sc_scan_reg <= '0;
                        sr_scan_reg <= sr_scan_reg + RW'(1);
                        scan_last_reg <= ((RW+1)'(sr_scan_reg) + (RW+2)'(2) >= (RW+2)'(nrows))
                                         && (ncols == (CW+1)'(1));
                    end
                    else
                    begin
                        sc_scan_reg <= sc_scan_reg + CW'(1);
                        scan_last_reg <= ((RW+1)'(sr_scan_reg) + (RW+1)'(1) >= nrows)
                                         && ((CW+1)'(sc_scan_reg) + (CW+1)'(2) >= ncols);
                    end
                end
                olab_reg <= LABEL_W'(lab_reg);
                odir_reg <= '0;
            end

            if (state_reg == S_NB)
            begin
                if (nb_hit)
                begin
                    // hit on the previous direction's read
                    lzd_reg   <= zero_dir(dir_reg - 3'd1);
                    cr_reg    <= nr_reg;
                    cc_reg    <= nc_reg;
                    okind_reg <= KIND_STEP;
                    orow_reg  <= DIM_W'(nr_reg);
                    ocol_reg  <= DIM_W'(nc_reg);
                    odir_reg  <= dir_reg - 3'd1;
                    if (nr_reg == sr_reg && nc_reg == sc_reg)
                    begin
                        oend_reg  <= 1'b1;
                        lab_reg   <= lab_reg + LABEL_BITS'(1);
                        phase_reg <= PH_SEEK;
                    end
                    else
                        oend_reg <= 1'b0;
                end
                else if (cnt_reg == 4'd8)
                begin
                    okind_reg <= KIND_ISOLATED;
                    orow_reg  <= DIM_W'(cr_reg);
                    ocol_reg  <= DIM_W'(cc_reg);
                    odir_reg  <= '0;
                    oend_reg  <= 1'b1;
                    lab_reg   <= lab_reg + LABEL_BITS'(1);
                    phase_reg <= PH_SEEK;
                end
                else
                begin
                    nb_pend_reg <= 1'b1;
                    nb_out_reg  <= !nb_in;
                    nr_reg      <= ncr;
                    nc_reg      <= ncc;
                    dir_reg     <= dir_reg + 3'd1;
                    cnt_reg     <= cnt_reg + 4'd1;
                end
                olab_reg <= LABEL_W'(lab_reg);
            end

            if (state_reg == S_SEEKW && state_next == S_OUT)
            begin
                if (ram_rdata != lab_reg)
                    phase_reg <= PH_SEEK;
            end

            if (state_reg == S_OUT)
            begin
                ovalid_reg <= 1'b1;
                hold_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_op_reg <= op;
            hold_px_reg <= LABEL_BITS'(pixel_value);
        end
    end

    assign out_valid     = ovalid_reg;
    assign kind          = okind_reg;
    assign row           = orow_reg;
    assign col           = ocol_reg;
    assign label         = olab_reg;
    assign direction     = odir_reg;
    assign component_end = oend_reg;

endmodule
